>>> hdl/mbps_pkg.sv
// Shared types and constants of the masked byte pattern scanner.
`timescale 1ns / 1ps

package mbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int OFFSET_W    = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_CARE_MASK      = 2'd2,
        CFG_PATTERN_LENGTH = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
    } t_cell_link;

    typedef struct packed {
        logic [7:0] data;
        logic       care;
    } t_cell_ref;

endpackage

>>> hdl/mbps_cell.sv
// One window cell: holds a byte of the current chunk and compares it with its pattern byte.
`timescale 1ns / 1ps

module mbps_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_shift,
    input  mbps_pkg::t_cell_link i_link,
    input  mbps_pkg::t_cell_ref  i_ref,
    output mbps_pkg::t_cell_link o_link,
    output logic               o_ok
);

    logic [7:0] r_data;
    logic       r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_link.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_link.data;
        end
    end

    assign o_link.data  = r_data;
    assign o_link.valid = r_valid;
    assign o_ok         = !i_ref.care || (r_data == i_ref.data);

endmodule

>>> hdl/masked_byte_pattern_scanner.sv
// Top level of the masked byte pattern scanner: configuration, cell chain and output word.
`timescale 1ns / 1ps

// The input channel (i_in_valid, o_in_stall) carries one data byte per word, with
// i_chunk_start marking the first byte of a chunk and i_chunk_base giving its offset.
// Bytes enter a chain of sixteen cells, newest in cell 0; each cell compares its byte
// with the pattern byte aligned to it, and a masked AND over the cells gives a hit.
// A word is taken every cycle while o_in_stall is low. A hit is found once its byte is
// in the cells, then loaded into the output register, and leaves as one word on
// (o_out_valid, i_out_stall) carrying o_match_offset, the offset of the first matched
// byte. The output register parts the two channels: while a result waits, the compare
// stage still takes a byte; only when that stage holds a second hit does o_in_stall
// rise. Bytes without a hit never stall. Configuration is written through (i_cfg_valid,
// o_cfg_ready), ready whenever reset is released; the user writes it only while the block
// is idle, which the block does not enforce. Reset clears the configuration, valid bits
// and running offset; it holds o_in_stall high, and the stream is one chunk at base zero.
module masked_byte_pattern_scanner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_chunk_start,
    input  logic [mbps_pkg::OFFSET_W-1:0]       i_chunk_base,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [mbps_pkg::OFFSET_W-1:0]       o_match_offset,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [63:0]                         i_cfg_data
);

    logic [63:0]                          r_pattern_low;
    logic [63:0]                          r_pattern_high;
    logic [mbps_pkg::MAX_PATTERN-1:0]     r_care_mask;
    logic [mbps_pkg::LEN_W-1:0]           r_pattern_length;

    logic [mbps_pkg::OFFSET_W-1:0]        r_next_offset;
    logic [mbps_pkg::OFFSET_W-1:0]        n_here;
    logic [mbps_pkg::OFFSET_W-1:0]        r_s1_here;
    logic                                 r_s1_valid;
    logic                                 r_out_valid;
    logic [mbps_pkg::OFFSET_W-1:0]        r_out_offset;

    logic [mbps_pkg::LEN_W-1:0]           len_eff;
    logic [mbps_pkg::IDX_W-1:0]           last_idx;
    logic [8*mbps_pkg::MAX_PATTERN-1:0]   pattern_all;
    mbps_pkg::t_cell_ref                  cell_ref  [mbps_pkg::MAX_PATTERN];
    mbps_pkg::t_cell_link                 cell_in   [mbps_pkg::MAX_PATTERN];
    mbps_pkg::t_cell_link                 cell_out  [mbps_pkg::MAX_PATTERN];
    logic [mbps_pkg::MAX_PATTERN-1:0]     cell_ok;
    logic [mbps_pkg::MAX_PATTERN-1:0]     cell_valid;

    logic in_accept;
    logic s1_hit;
    logic s1_move;
    logic out_take;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_care_mask      <= '0;
            r_pattern_length <= '0;
        end else if (i_cfg_valid) begin
            case (mbps_pkg::t_cfg_index'(i_cfg_index))
                mbps_pkg::CFG_PATTERN_LOW:    r_pattern_low    <= i_cfg_data;
                mbps_pkg::CFG_PATTERN_HIGH:   r_pattern_high   <= i_cfg_data;
                mbps_pkg::CFG_CARE_MASK:
                    r_care_mask <= i_cfg_data[mbps_pkg::MAX_PATTERN-1:0];
                mbps_pkg::CFG_PATTERN_LENGTH:
                    r_pattern_length <= i_cfg_data[mbps_pkg::LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign len_eff = (r_pattern_length > mbps_pkg::LEN_W'(mbps_pkg::MAX_PATTERN))
                   ? mbps_pkg::LEN_W'(mbps_pkg::MAX_PATTERN) : r_pattern_length;
    assign last_idx    = mbps_pkg::IDX_W'(len_eff - mbps_pkg::LEN_W'(1));
    assign pattern_all = {r_pattern_high, r_pattern_low};

    // Cell k holds the byte k places back, so it meets pattern byte len-1-k.
    always_comb begin
        logic [mbps_pkg::LEN_W-1:0] pos;
        for (int k = 0; k < mbps_pkg::MAX_PATTERN; k++) begin
            pos = len_eff - mbps_pkg::LEN_W'(k + 1);
            if (mbps_pkg::LEN_W'(k) < len_eff) begin
                cell_ref[k].data = pattern_all[8*pos[mbps_pkg::IDX_W-1:0] +: 8];
                cell_ref[k].care = r_care_mask[pos[mbps_pkg::IDX_W-1:0]];
            end else begin
                cell_ref[k].data = '0;
                cell_ref[k].care = 1'b0;
            end
        end
    end

    always_comb begin
        cell_in[0].data  = i_data_byte;
        cell_in[0].valid = 1'b1;
        for (int k = 1; k < mbps_pkg::MAX_PATTERN; k++) begin
            cell_in[k].data  = cell_out[k-1].data;
            cell_in[k].valid = cell_out[k-1].valid && !i_chunk_start;
        end
    end

    for (genvar g = 0; g < mbps_pkg::MAX_PATTERN; g++) begin : g_cell
        mbps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (in_accept),
            .i_link  (cell_in[g]),
            .i_ref   (cell_ref[g]),
            .o_link  (cell_out[g]),
            .o_ok    (cell_ok[g])
        );
        assign cell_valid[g] = cell_out[g].valid;
    end

    assign s1_hit    = r_s1_valid && (len_eff != '0) && cell_valid[last_idx] && (&cell_ok);
    assign out_take  = r_out_valid && !i_out_stall;
    assign s1_move   = !s1_hit || !r_out_valid || !i_out_stall;
    assign o_in_stall = !i_rst_n || (r_s1_valid && !s1_move);
    assign in_accept = i_in_valid && !o_in_stall;
    assign n_here    = i_chunk_start ? i_chunk_base : r_next_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_offset <= '0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_accept) begin
                r_next_offset <= n_here + mbps_pkg::OFFSET_W'(1);
                r_s1_valid    <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid    <= 1'b0;
            end
            if (s1_hit && s1_move) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_here <= n_here;
        end
        if (s1_hit && s1_move) begin
            r_out_offset <= r_s1_here - mbps_pkg::OFFSET_W'(last_idx);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_match_offset = r_out_offset;

endmodule
